// ===== design/ia64_pkg.sv =====
// ----------------------------------------------------------------------------
// ia64_pkg
// Shared types and constants for the signed 64-bit interval arithmetic unit.
// ----------------------------------------------------------------------------
package ia64_pkg;

	localparam int DATA_WIDTH = 64;

	typedef logic signed [DATA_WIDTH-1:0] word_t;
	typedef logic [DATA_WIDTH-1:0] uword_t;

	localparam word_t VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam word_t VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam word_t TOP_COUNT = word_t'(DATA_WIDTH - 1);

	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_REM = 3'd3,
		CMD_SHL = 3'd4,
		CMD_SAR = 3'd5
	} cmd_t;

endpackage

// ===== design/int64_interval_arithmetic.sv =====
// ----------------------------------------------------------------------------
// int64_interval_arithmetic
// Pipelined interval add, subtract, multiply, remainder and shifts.
// ----------------------------------------------------------------------------
// channel   direction  strobe / ready   payload
// query     in         start / busy     command, first_low/high, second_low/high
// answer    out        done             ok, result_low, result_high
//
// A transaction is taken on any cycle with start high; busy stays low.
// Each answer passes the stage 1, 2 and 3 registers and the output register; answers come in order, one per cycle.
// Four stages: decode and corner setup, 32x32 partial products,
// product assembly and overflow check, min/max selection.
// Reset clears the stage valid bits and the done strobe.
// The receiver cannot stall; the pipeline never holds.
// ----------------------------------------------------------------------------
module int64_interval_arithmetic (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [2:0]            command,
	input  ia64_pkg::word_t       first_low,
	input  ia64_pkg::word_t       first_high,
	input  ia64_pkg::word_t       second_low,
	input  ia64_pkg::word_t       second_high,
	output logic                  done,
	output logic                  ok,
	output ia64_pkg::word_t       result_low,
	output ia64_pkg::word_t       result_high
);

	localparam int DW = ia64_pkg::DATA_WIDTH;
	localparam int HW = DW / 2;

	logic                 v_s1, v_s2, v_s3;
	logic                 ok_s1, ok_s2, ok_s3;
	logic                 mul_s1, mul_s2;
	logic [3:0]           neg_s1, neg_s2;
	ia64_pkg::uword_t     ma_s1 [2];
	ia64_pkg::uword_t     mb_s1 [2];
	ia64_pkg::word_t      cand_s1 [4];
	ia64_pkg::word_t      cand_s2 [4];
	ia64_pkg::word_t      cand_s3 [4];
	ia64_pkg::uword_t     pp_s2 [4][4];

	logic                 done_q, ok_q;
	ia64_pkg::word_t      rl_q, rh_q;

	// stage 1 decode
	logic                 ok_d, mul_d;
	logic [3:0]           neg_d;
	ia64_pkg::uword_t     ma_d [2];
	ia64_pkg::uword_t     mb_d [2];
	ia64_pkg::word_t      cand_d [4];
	logic signed [DW:0]   sum_l, sum_h;
	ia64_pkg::uword_t     m0, m1, dm;
	ia64_pkg::word_t      rm;
	ia64_pkg::word_t      av [2];
	ia64_pkg::word_t      bv [2];

	always_comb begin
		av[0] = first_low;
		av[1] = first_high;
		bv[0] = second_low;
		bv[1] = second_high;
		ok_d = (first_low <= first_high) && (second_low <= second_high);
		mul_d = 1'b0;
		for (int i = 0; i < 4; i++) cand_d[i] = '0;
		for (int i = 0; i < 2; i++) begin
			ma_d[i] = av[i][DW-1] ? ia64_pkg::uword_t'(-av[i]) : ia64_pkg::uword_t'(av[i]);
			mb_d[i] = bv[i][DW-1] ? ia64_pkg::uword_t'(-bv[i]) : ia64_pkg::uword_t'(bv[i]);
		end
		for (int i = 0; i < 2; i++)
			for (int j = 0; j < 2; j++)
				neg_d[i*2+j] = (av[i][DW-1] != bv[j][DW-1]) && (av[i] != '0) && (bv[j] != '0);
		sum_l = '0;
		sum_h = '0;
		m0 = mb_d[0];
		m1 = mb_d[1];
		dm = (m0 > m1) ? m0 : m1;
		rm = (dm > ia64_pkg::uword_t'(ia64_pkg::VMAX)) ? ia64_pkg::VMAX
			: ia64_pkg::word_t'(dm - 1'b1);
		case (command)
			ia64_pkg::CMD_ADD: begin
				sum_l = {first_low[DW-1], first_low} + {second_low[DW-1], second_low};
				sum_h = {first_high[DW-1], first_high} + {second_high[DW-1], second_high};
				if ((sum_l[DW] != sum_l[DW-1]) || (sum_h[DW] != sum_h[DW-1])) ok_d = 1'b0;
				cand_d[0] = sum_l[DW-1:0];
				cand_d[1] = sum_h[DW-1:0];
				cand_d[2] = sum_l[DW-1:0];
				cand_d[3] = sum_h[DW-1:0];
			end
			ia64_pkg::CMD_SUB: begin
				sum_l = {first_low[DW-1], first_low} - {second_high[DW-1], second_high};
				sum_h = {first_high[DW-1], first_high} - {second_low[DW-1], second_low};
				if ((sum_l[DW] != sum_l[DW-1]) || (sum_h[DW] != sum_h[DW-1])) ok_d = 1'b0;
				cand_d[0] = sum_l[DW-1:0];
				cand_d[1] = sum_h[DW-1:0];
				cand_d[2] = sum_l[DW-1:0];
				cand_d[3] = sum_h[DW-1:0];
			end
			ia64_pkg::CMD_MUL: begin
				mul_d = 1'b1;
			end
			ia64_pkg::CMD_REM: begin
				if ((second_low <= 0 && second_high >= 0) ||
				    (first_low == ia64_pkg::VMIN && second_low <= -1 && second_high >= -1))
					ok_d = 1'b0;
				cand_d[0] = (first_low >= 0) ? '0 : -rm;
				cand_d[1] = (first_high <= 0) ? '0 : rm;
				cand_d[2] = cand_d[0];
				cand_d[3] = cand_d[1];
			end
			ia64_pkg::CMD_SHL: begin
				if (second_low < 0 || second_high > ia64_pkg::TOP_COUNT) begin
					ok_d = 1'b0;
				end else if (second_high == ia64_pkg::TOP_COUNT) begin
					if (first_low < -1 || first_high > 0) ok_d = 1'b0;
					cand_d[0] = (first_low == -1) ? ia64_pkg::VMIN : '0;
				end else begin
					mul_d = 1'b1;
					mb_d[0] = ia64_pkg::uword_t'(1) << second_low[5:0];
					mb_d[1] = ia64_pkg::uword_t'(1) << second_high[5:0];
					for (int i = 0; i < 2; i++)
						for (int j = 0; j < 2; j++)
							neg_d[i*2+j] = av[i][DW-1];
				end
			end
			ia64_pkg::CMD_SAR: begin
				if (second_low < 0 || second_high > ia64_pkg::TOP_COUNT) ok_d = 1'b0;
				cand_d[0] = first_low >>> second_low[5:0];
				cand_d[1] = first_low >>> second_high[5:0];
				cand_d[2] = first_high >>> second_low[5:0];
				cand_d[3] = first_high >>> second_high[5:0];
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			done_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1 <= ok_d;
		mul_s1 <= mul_d;
		neg_s1 <= neg_d;
		ma_s1 <= ma_d;
		mb_s1 <= mb_d;
		cand_s1 <= cand_d;
	end

	// stage 2 partial products
	always_ff @(posedge clk) begin
		ok_s2 <= ok_s1;
		mul_s2 <= mul_s1;
		neg_s2 <= neg_s1;
		cand_s2 <= cand_s1;
		for (int i = 0; i < 2; i++)
			for (int j = 0; j < 2; j++) begin
				pp_s2[i*2+j][0] <= ia64_pkg::uword_t'(ma_s1[i][HW-1:0])
					* ia64_pkg::uword_t'(mb_s1[j][HW-1:0]);
				pp_s2[i*2+j][1] <= ia64_pkg::uword_t'(ma_s1[i][HW-1:0])
					* ia64_pkg::uword_t'(mb_s1[j][DW-1:HW]);
				pp_s2[i*2+j][2] <= ia64_pkg::uword_t'(ma_s1[i][DW-1:HW])
					* ia64_pkg::uword_t'(mb_s1[j][HW-1:0]);
				pp_s2[i*2+j][3] <= ia64_pkg::uword_t'(ma_s1[i][DW-1:HW])
					* ia64_pkg::uword_t'(mb_s1[j][DW-1:HW]);
			end
	end

	// stage 3 product assembly
	logic [2*DW-1:0]      prod [4];
	logic                 ok_p;
	ia64_pkg::word_t      cand_p [4];
	ia64_pkg::uword_t     limit;

	always_comb begin
		ok_p = ok_s2;
		cand_p = cand_s2;
		for (int k = 0; k < 4; k++) begin
			prod[k] = {{DW{1'b0}}, pp_s2[k][0]}
				+ ({{DW{1'b0}}, pp_s2[k][1]} << HW)
				+ ({{DW{1'b0}}, pp_s2[k][2]} << HW)
				+ {pp_s2[k][3], {DW{1'b0}}};
			limit = neg_s2[k] ? ia64_pkg::uword_t'(ia64_pkg::VMIN)
				: ia64_pkg::uword_t'(ia64_pkg::VMAX);
			if (mul_s2) begin
				if ((prod[k][2*DW-1:DW] != '0) || (prod[k][DW-1:0] > limit)) ok_p = 1'b0;
				cand_p[k] = neg_s2[k] ? -ia64_pkg::word_t'(prod[k][DW-1:0])
					: ia64_pkg::word_t'(prod[k][DW-1:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		ok_s3 <= ok_p;
		cand_s3 <= cand_p;
	end

	// stage 4 bounds
	ia64_pkg::word_t      lo_m, hi_m;

	always_comb begin
		lo_m = cand_s3[0];
		hi_m = cand_s3[0];
		for (int k = 1; k < 4; k++) begin
			if (cand_s3[k] < lo_m) lo_m = cand_s3[k];
			if (cand_s3[k] > hi_m) hi_m = cand_s3[k];
		end
	end

	always_ff @(posedge clk) begin
		ok_q <= ok_s3;
		rl_q <= ok_s3 ? lo_m : '0;
		rh_q <= ok_s3 ? hi_m : '0;
	end

	assign busy = 1'b0;
	assign done = done_q;
	assign ok = ok_q;
	assign result_low = rl_q;
	assign result_high = rh_q;

endmodule

// ===== design/ia64_checker.sv =====
// ----------------------------------------------------------------------------
// ia64_checker
// Port-level checks for the interval arithmetic unit.
// ----------------------------------------------------------------------------
module ia64_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  done,
	input logic                  ok,
	input ia64_pkg::word_t       result_low,
	input ia64_pkg::word_t       result_high
);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done) else $error("answer missing");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		(!start) |-> ##4 !done) else $error("spurious answer");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> (result_low == '0 && result_high == '0))
		else $error("failed answer not zero");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ok) |-> (result_low <= result_high)) else $error("bounds reversed");

endmodule

bind int64_interval_arithmetic ia64_checker u_ia64_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.ok(ok),
	.result_low(result_low),
	.result_high(result_high)
);

// ===== tb/int64_interval_arithmetic_checker.sv =====
// ----------------------------------------------------------------------------
// int64_interval_arithmetic_checker
// Watches the query and answer channels of the interval arithmetic unit,
// predicts each answer from the accepted query and compares it field by field.
// ----------------------------------------------------------------------------
module int64_interval_arithmetic_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  logic [2:0]      command,
	input  ia64_pkg::word_t first_low,
	input  ia64_pkg::word_t first_high,
	input  ia64_pkg::word_t second_low,
	input  ia64_pkg::word_t second_high,
	input  logic            done,
	input  logic            ok,
	input  ia64_pkg::word_t result_low,
	input  ia64_pkg::word_t result_high,
	output int              failures,
	output int              pending,
	output int              answers_seen,
	output int              valid_answers
);
	import ia64_pkg::*;

	typedef struct packed {
		logic  ok;
		word_t lo;
		word_t hi;
	} answer_t;

	answer_t expected_answers[$];

	function automatic logic checked_product(input word_t a, input word_t b, output word_t p);
		logic signed [127:0] full;
		full = 128'(a) * 128'(b);
		p = full[63:0];
		return (full >= 128'(VMIN) && full <= 128'(VMAX));
	endfunction

	function automatic logic corner_products(input word_t al, input word_t ah,
			input word_t bl, input word_t bh, output word_t lo, output word_t hi);
		word_t p[4];
		logic fits;
		fits = checked_product(al, bl, p[0]);
		fits &= checked_product(al, bh, p[1]);
		fits &= checked_product(ah, bl, p[2]);
		fits &= checked_product(ah, bh, p[3]);
		lo = p[0];
		hi = p[0];
		for (int i = 1; i < 4; i++) begin
			if (p[i] < lo) lo = p[i];
			if (p[i] > hi) hi = p[i];
		end
		return fits;
	endfunction

	function automatic answer_t interval_answer(input logic [2:0] cmd, input word_t al,
			input word_t ah, input word_t bl, input word_t bh);
		answer_t r;
		logic signed [64:0] wl, wh;
		logic [63:0] ml, mh, dm;
		word_t rm;
		word_t s[4];
		r = '0;
		r.ok = (al <= ah) && (bl <= bh);
		if (r.ok) begin
			case (cmd)
				CMD_ADD: begin
					wl = 65'(al) + 65'(bl);
					wh = 65'(ah) + 65'(bh);
					r.ok = wl >= 65'(VMIN) && wh <= 65'(VMAX);
					r.lo = wl[63:0];
					r.hi = wh[63:0];
				end
				CMD_SUB: begin
					wl = 65'(al) - 65'(bh);
					wh = 65'(ah) - 65'(bl);
					r.ok = wl >= 65'(VMIN) && wh <= 65'(VMAX);
					r.lo = wl[63:0];
					r.hi = wh[63:0];
				end
				CMD_MUL: r.ok = corner_products(al, ah, bl, bh, r.lo, r.hi);
				CMD_REM: begin
					if ((bl <= 0 && bh >= 0) || (al == VMIN && bl <= -1 && bh >= -1)) begin
						r.ok = 0;
					end else begin
						ml = bl < 0 ? -bl : bl;
						mh = bh < 0 ? -bh : bh;
						dm = ml > mh ? ml : mh;
						rm = dm > 64'(VMAX) ? VMAX : word_t'(dm - 1);
						r.lo = al >= 0 ? 64'sd0 : -rm;
						r.hi = ah <= 0 ? 64'sd0 : rm;
					end
				end
				CMD_SHL: begin
					if (bl < 0 || bh > TOP_COUNT) begin
						r.ok = 0;
					end else if (bh == TOP_COUNT) begin
						r.ok = al >= -1 && ah <= 0;
						r.lo = al == -1 ? VMIN : 64'sd0;
						r.hi = 0;
					end else begin
						r.ok = corner_products(al, ah, word_t'(64'd1 << bl),
							word_t'(64'd1 << bh), r.lo, r.hi);
					end
				end
				CMD_SAR: begin
					if (bl < 0 || bh > TOP_COUNT) begin
						r.ok = 0;
					end else begin
						s[0] = al >>> bl[5:0];
						s[1] = al >>> bh[5:0];
						s[2] = ah >>> bl[5:0];
						s[3] = ah >>> bh[5:0];
						r.lo = s[0];
						r.hi = s[0];
						for (int i = 1; i < 4; i++) begin
							if (s[i] < r.lo) r.lo = s[i];
							if (s[i] > r.hi) r.hi = s[i];
						end
					end
				end
				default: r.ok = 0;
			endcase
		end
		if (!r.ok) begin
			r.lo = 0;
			r.hi = 0;
		end
		return r;
	endfunction

	assign pending = expected_answers.size();

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			failures <= 0;
			answers_seen <= 0;
			valid_answers <= 0;
			expected_answers.delete();
		end else begin
			if (done) begin
				answers_seen <= answers_seen + 1;
				valid_answers <= valid_answers + ok;
				if (expected_answers.size() == 0) begin
					if (failures < 10)
						$display("unexpected answer ok=%0b lo=%0d hi=%0d", ok, result_low,
							result_high);
					failures <= failures + 1;
				end else begin
					want = expected_answers.pop_front();
					if (want.ok !== ok || want.lo !== result_low || want.hi !== result_high) begin
						if (failures < 10)
							$display("mismatch: expected ok=%0b [%0d,%0d] got ok=%0b [%0d,%0d]",
								want.ok, want.lo, want.hi, ok, result_low, result_high);
						failures <= failures + 1;
					end
				end
			end
			if (start && !busy)
				expected_answers.push_back(interval_answer(command, first_low, first_high,
					second_low, second_high));
		end
	end
endmodule

// ===== tb/int64_interval_arithmetic_tb.sv =====
// ----------------------------------------------------------------------------
// int64_interval_arithmetic_tb
// Drives directed and random interval queries through the unit in several
// idling phases; a checker module predicts and compares every answer.
// ----------------------------------------------------------------------------
module int64_interval_arithmetic_tb;
	import ia64_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [2:0] command = '0;
	word_t first_low = 0, first_high = 0, second_low = 0, second_high = 0;
	logic done, ok;
	word_t result_low, result_high;
	int failures, pending, answers_seen, valid_answers;
	int idle_pct = 0;
	int quiet_cycles = 0;
	int accepted = 0;

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	int64_interval_arithmetic dut (.*);

	int64_interval_arithmetic_checker checker_i (.*);

	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (start && !busy) accepted <= accepted + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("int64_interval_arithmetic_tb failed");
			$finish;
		end
	end

	function automatic word_t pick_value();
		case ($urandom_range(0, 7))
			0: return VMIN + $urandom_range(0, 3);
			1: return VMAX - $urandom_range(0, 3);
			2: return $signed($urandom_range(0, 20)) - 10;
			3: return {$urandom, $urandom};
			4: return word_t'($signed($urandom)) >>> $urandom_range(0, 31);
			5: return word_t'(1) <<< $urandom_range(0, 63);
			default: return $signed($urandom_range(0, 2000)) - 1000;
		endcase
	endfunction

	task automatic send(input logic [2:0] c, input word_t al, input word_t ah,
			input word_t bl, input word_t bh);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 0;
			@(negedge clk);
		end
		start <= 1;
		command <= c;
		first_low <= al;
		first_high <= ah;
		second_low <= bl;
		second_high <= bh;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random();
		logic [2:0] c;
		word_t a0, a1, b0, b1, t;
		c = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
		a0 = pick_value();
		a1 = pick_value();
		if (c == CMD_SHL || c == CMD_SAR) begin
			b0 = $urandom_range(0, 63);
			b1 = $urandom_range(0, 63);
			if ($urandom_range(0, 9) == 0) b1 = pick_value();
			if (c == CMD_SHL && $urandom_range(0, 1)) begin
				a0 = $signed($urandom_range(0, 200)) - 100;
				a1 = a0 + $urandom_range(0, 50);
			end
		end else if (c == CMD_MUL && $urandom_range(0, 1)) begin
			a0 = word_t'($signed($urandom));
			a1 = word_t'($signed($urandom));
			b0 = word_t'($signed($urandom)) >>> $urandom_range(0, 31);
			b1 = word_t'($signed($urandom)) >>> $urandom_range(0, 31);
		end else begin
			b0 = pick_value();
			b1 = pick_value();
		end
		if ($urandom_range(0, 9) != 0) begin
			if (a0 > a1) begin t = a0; a0 = a1; a1 = t; end
			if (b0 > b1) begin t = b0; b0 = b1; b1 = t; end
		end
		send(c, a0, a1, b0, b1);
	endtask

	initial begin
		int phase_pct[4] = '{0, 59, 0, 37};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		send(CMD_ADD, VMAX, VMAX, 0, 0);
		send(CMD_ADD, VMAX, VMAX, 1, 1);
		send(CMD_ADD, VMIN, VMIN, -1, -1);
		send(CMD_SUB, VMIN, VMIN, 1, 1);
		send(CMD_SUB, 0, 0, VMIN, VMIN);
		send(CMD_SUB, -5, 7, -3, 9);
		send(CMD_MUL, VMIN, VMIN, -1, -1);
		send(CMD_MUL, VMIN, VMIN, 1, 1);
		send(CMD_MUL, -4, 9, -3, 8);
		send(CMD_MUL, 64'sh1_0000_0000, 64'sh1_0000_0000, 64'sh8000_0000, 64'sh8000_0000);
		send(CMD_REM, -100, 100, -3, 5);
		send(CMD_REM, VMIN, 10, -2, -1);
		send(CMD_REM, VMIN, VMIN, VMIN, VMIN);
		send(CMD_REM, -100, 100, 3, 7);
		send(CMD_SHL, 1, 3, 0, 62);
		send(CMD_SHL, -1, 0, 63, 63);
		send(CMD_SHL, 0, 1, 63, 63);
		send(CMD_SHL, 1, 1, -1, 3);
		send(CMD_SAR, VMIN, VMAX, 0, 63);
		send(CMD_SAR, -7, 7, 1, 64);
		send(3'd6, 1, 2, 3, 4);
		send(3'd7, 1, 2, 3, 4);
		send(CMD_ADD, 5, 4, 0, 0);
		send(CMD_ADD, 0, 0, -1, -2);
		send(CMD_ADD, -64'sd1, -64'sd1, 64'sd0, 64'sd0);
		start <= 0;
		while (pending != 0) @(negedge clk);
		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_pct[p];
			repeat (400) send_random();
			if (p == 1) begin
				start <= 0;
				while (pending != 0) @(negedge clk);
			end
		end
		start <= 0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		$display("ran %0d queries, %0d answers, %0d with a proven interval", accepted,
			answers_seen, valid_answers);
		if (failures == 0 && pending == 0)
			$display("int64_interval_arithmetic_tb passed");
		else
			$display("int64_interval_arithmetic_tb failed");
		$finish;
	end
endmodule
